/* hw/rtl/ncc_pkg.sv */
// -----------------------------------------------------------------------------
// ncc_pkg: shared constants and types of the nearest centroid classifier
// Sizes of the centroid store, accumulator widths, word layouts and the
// control structs passed between the sequencer and the distance unit.
// -----------------------------------------------------------------------------
package ncc_pkg;

   // sizing
   localparam int MAX_CENTROIDS    = 16;
   localparam int MAX_CLIP_SAMPLES = 512;
   localparam int SAMPLE_BITS      = 16;

   localparam int STORE_DEPTH = MAX_CENTROIDS * MAX_CLIP_SAMPLES;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int IDX_BITS    = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int NCENT_BITS  = $clog2(MAX_CENTROIDS + 1);
   localparam int NSAMP_BITS  = $clog2(MAX_CLIP_SAMPLES + 1);

   // arithmetic
   localparam int ACC_BITS = 45;
   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int SUM_BITS = ((SQ_BITS > ACC_BITS) ? SQ_BITS : ACC_BITS) + 1;

   // field widths
   localparam int MODE_BITS     = 1;
   localparam int SLOT_BITS     = 4;
   localparam int POS_BITS      = 9;
   localparam int VALUE_BITS    = 16;
   localparam int LABEL_BITS    = 5;
   localparam int CC_BITS       = 5;
   localparam int CSC_BITS      = 10;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 10;

   // word layouts
   localparam int IN_TDATA_BITS  = 32;
   localparam int OUT_TDATA_BITS = 56;

   // mode codes
   localparam logic [MODE_BITS-1:0] MODE_LOAD = 1'b0;
   localparam logic [MODE_BITS-1:0] MODE_CLIP = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTROID_COUNT    = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_SAMPLE_COUNT = 1'd1;

   // one visit of the shared unit
   typedef struct packed {
      logic                valid;
      logic [IDX_BITS-1:0] idx;
      logic                last;
   } ncc_issue_type;

   // distance unit status back to the sequencer
   typedef struct packed {
      logic                busy;
      logic [IDX_BITS-1:0] best_idx;
      logic [ACC_BITS-1:0] min_sum;
   } ncc_status_type;

endpackage

/* hw/rtl/ncc_ram.sv */
// -----------------------------------------------------------------------------
// ncc_ram: generic single-port RAM
// One address shared by write and read; read data registered.
// -----------------------------------------------------------------------------
module ncc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ncc_dist_unit.sv */
// -----------------------------------------------------------------------------
// ncc_dist_unit: shared subtract-square-accumulate unit
// Four stages: difference, square, saturating accumulate, running minimum.
// Holds the per-centroid accumulators.
// -----------------------------------------------------------------------------
module ncc_dist_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  ncc_pkg::ncc_issue_type         issue,
   input  logic [ncc_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [ncc_pkg::SAMPLE_BITS-1:0] centroid,
   input  logic                           clear,
   output ncc_pkg::ncc_status_type        status
);
   import ncc_pkg::*;

   // stage 1: registered issue lines up with the RAM read data
   ncc_issue_type s1_ff;
   // stage 2: absolute difference
   ncc_issue_type s2_ff;
   logic [SAMPLE_BITS-1:0] absd_ff;
   // stage 3: square
   ncc_issue_type s3_ff;
   logic [SQ_BITS-1:0] sq_ff;
   // stage 4: updated accumulator value
   ncc_issue_type s4_ff;
   logic [ACC_BITS-1:0] new_ff;

   logic [ACC_BITS-1:0] acc_ff [MAX_CENTROIDS];
   logic [IDX_BITS-1:0] best_idx_ff;
   logic [ACC_BITS-1:0] min_sum_ff;

   logic signed [SAMPLE_BITS:0] diff;
   logic [SAMPLE_BITS:0]        diff_mag;
   logic [SUM_BITS-1:0]         sum;
   logic [ACC_BITS-1:0]         acc_in;

   always_comb begin
      diff     = $signed({sample[SAMPLE_BITS-1], sample})
               - $signed({centroid[SAMPLE_BITS-1], centroid});
      diff_mag = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
      sum      = SUM_BITS'(acc_ff[s3_ff.idx]) + SUM_BITS'(sq_ff);
      if (sum[SUM_BITS-1:ACC_BITS] != '0) begin
         acc_in = '1;           // saturate at top value
      end else begin
         acc_in = sum[ACC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      absd_ff <= diff_mag[SAMPLE_BITS-1:0];
      sq_ff   <= SQ_BITS'(absd_ff) * SQ_BITS'(absd_ff);
      new_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < MAX_CENTROIDS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (s3_ff.valid) begin
         acc_ff[s3_ff.idx] <= acc_in;
      end
   end

   // strict less-than in rising index order: ties keep the lower index
   always_ff @(posedge clock) begin
      if (s4_ff.valid && s4_ff.last) begin
         if (s4_ff.idx == '0 || new_ff < min_sum_ff) begin
            best_idx_ff <= s4_ff.idx;
            min_sum_ff  <= new_ff;
         end
      end
   end

   assign status.busy     = s1_ff.valid | s2_ff.valid | s3_ff.valid | s4_ff.valid;
   assign status.best_idx = best_idx_ff;
   assign status.min_sum  = min_sum_ff;

endmodule

/* hw/rtl/nearest_centroid_classifier.sv */
// -----------------------------------------------------------------------------
// nearest_centroid_classifier: Euclidean nearest-centroid label per clip
// Load word: ready stays high. Clip word: ready goes low after the accept
//   while it issues one visit per active centroid to the single shared
//   subtract-square-accumulate unit, then drains its 4 stages (plus the
//   empty check), so the next word goes in only once the unit is empty.
// The clip's last word adds an emit state (held while the output reg is held);
// the result word is valid in the cycle after the emit.
// Reset (sync, active high): registers to 1 and 512, accumulators cleared,
//   sequencer idle, no result pending. Centroid store is not cleared.
// -----------------------------------------------------------------------------
module nearest_centroid_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   // input words
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ncc_pkg::IN_TDATA_BITS-1:0]    req_tdata,   // slot, sample_position, sample_value
   input  logic [ncc_pkg::MODE_BITS-1:0]        req_tuser,   // mode
   // result words
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ncc_pkg::OUT_TDATA_BITS-1:0]   rsp_tdata,   // best_label, best_distance_sq
   // register writes
   input  logic                                 csr_we,
   input  logic [ncc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ncc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import ncc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;  // take words
   localparam logic [1:0] ST_RUN   = 2'd1;  // issue one centroid per cycle
   localparam logic [1:0] ST_DRAIN = 2'd2;  // let the unit empty
   localparam logic [1:0] ST_EMIT  = 2'd3;  // hand result to output reg

   // word fields
   logic [MODE_BITS-1:0]  req_mode;
   logic [SLOT_BITS-1:0]  req_slot;
   logic [POS_BITS-1:0]   req_pos;
   logic [VALUE_BITS-1:0] req_value;

   // registers
   logic [CC_BITS-1:0]     centroid_count_ff;
   logic [CSC_BITS-1:0]    clip_sample_count_ff;
   logic [1:0]             state_ff, state_in;
   logic [NCENT_BITS-1:0]  k_ff, k_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // effective counts
   logic [NCENT_BITS-1:0] ncent;
   logic [NSAMP_BITS-1:0] nsamp;

   logic                   accept;
   logic                   in_clip;
   logic                   store_we;
   logic [ADDR_BITS-1:0]   store_addr;
   logic [SAMPLE_BITS-1:0] store_rdata;
   logic                   clear;
   logic                   emit;
   ncc_issue_type          issue;
   ncc_status_type         status;

   assign req_slot  = req_tdata[SLOT_BITS-1:0];
   assign req_pos   = req_tdata[SLOT_BITS+POS_BITS-1:SLOT_BITS];
   assign req_value = req_tdata[SLOT_BITS+POS_BITS+VALUE_BITS-1:SLOT_BITS+POS_BITS];
   assign req_mode  = req_tuser;

   // zero counts as one, too large saturates
   always_comb begin
      if (centroid_count_ff == '0) begin
         ncent = NCENT_BITS'(1);
      end else if (32'(centroid_count_ff) > MAX_CENTROIDS) begin
         ncent = NCENT_BITS'(MAX_CENTROIDS);
      end else begin
         ncent = NCENT_BITS'(centroid_count_ff);
      end
      if (clip_sample_count_ff == '0) begin
         nsamp = NSAMP_BITS'(1);
      end else if (32'(clip_sample_count_ff) > MAX_CLIP_SAMPLES) begin
         nsamp = NSAMP_BITS'(MAX_CLIP_SAMPLES);
      end else begin
         nsamp = NSAMP_BITS'(clip_sample_count_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign in_clip    = 32'(req_pos) < 32'(nsamp);

   // output register frees up when taken
   assign emit  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign clear = emit;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      issue     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_CLIP && in_clip) begin
               state_in  = ST_RUN;
               k_in      = '0;
               pos_in    = req_pos;
               sample_in = SAMPLE_BITS'($signed(req_value));
               last_in   = (32'(req_pos) == 32'(nsamp) - 1);
            end
         end
         ST_RUN: begin
            issue.valid = 1'b1;
            issue.idx   = k_ff[IDX_BITS-1:0];
            issue.last  = last_ff;
            if (k_ff == ncent - NCENT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + NCENT_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // store port: loads while idle, centroid reads while running
   always_comb begin
      store_we = accept && req_mode == MODE_LOAD
               && 32'(req_slot) < MAX_CENTROIDS && 32'(req_pos) < MAX_CLIP_SAMPLES;
      if (state_ff == ST_RUN) begin
         store_addr = ADDR_BITS'(k_ff[IDX_BITS-1:0]) * ADDR_BITS'(MAX_CLIP_SAMPLES)
                    + ADDR_BITS'(pos_ff);
      end else begin
         store_addr = ADDR_BITS'(req_slot) * ADDR_BITS'(MAX_CLIP_SAMPLES)
                    + ADDR_BITS'(req_pos);
      end
   end

   // result word: label one-based, distance above it
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = OUT_TDATA_BITS'({status.min_sum,
                        LABEL_BITS'(LABEL_BITS'(status.best_idx) + LABEL_BITS'(1))});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         rsp_valid_ff         <= 1'b0;
         centroid_count_ff    <= CC_BITS'(1);
         clip_sample_count_ff <= CSC_BITS'(512);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CENTROID_COUNT:    centroid_count_ff    <= csr_wdata[CC_BITS-1:0];
               CSR_CLIP_SAMPLE_COUNT: clip_sample_count_ff <= csr_wdata[CSC_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   ncc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (store_we),
      .addr  (store_addr),
      .wdata (SAMPLE_BITS'($signed(req_value))),
      .rdata (store_rdata)
   );

   ncc_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .sample   (sample_ff),
      .centroid (store_rdata),
      .clear    (clear),
      .status   (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_idle_unit_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.busy)
      else $error("distance unit busy while sequencer idle");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (k_ff < ncent))
      else $error("centroid index past active count");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result word raised outside emit");

   a_emit_leaves: assert property (@(posedge clock) disable iff (reset)
      emit |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("emit did not load result and return idle");

endmodule

/* tb/tb_nearest_centroid_classifier.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_nearest_centroid_classifier: self-checking bench for the classifier
// Streams centroid loads and clip samples into the block under random
// sender bursts and receiver stalls. A bench-side model tracks the centroid
// store, the per-centroid distance sums and both count registers, and checks
// each label and distance word against the oldest expected word.
// -----------------------------------------------------------------------------
module tb_nearest_centroid_classifier;
   import ncc_pkg::*;

   localparam int RANDOM_WORDS   = 1350;  // stimulus stops once this many words count
   localparam int DRAIN_CYCLES   = 40;    // outlasts the worst clip word: all visits, drain and result
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int REPORT_LIMIT   = 10;
   localparam int SAMPLE_MAX     = 2 ** (VALUE_BITS - 1) - 1;
   localparam int SAMPLE_MIN     = -(2 ** (VALUE_BITS - 1));

   // one input word as the bench sees it
   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [SLOT_BITS-1:0]  slot;
      logic [POS_BITS-1:0]   pos;
      logic [VALUE_BITS-1:0] value;
   } sample_word_type;

   // one classification word
   typedef struct packed {
      logic [LABEL_BITS-1:0] label;
      logic [ACC_BITS-1:0]   distance;
   } class_result_type;

   // how clip sample values are picked
   typedef enum int {
      STYLE_NEAR,     // close to one chosen centroid
      STYLE_RANDOM,
      STYLE_EXTREME,
      STYLE_TINY      // small set of values, many ties
   } clip_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [IN_TDATA_BITS-1:0]  req_tdata = '0;   // slot, sample_position, sample_value
   logic [MODE_BITS-1:0]      req_tuser = MODE_LOAD;  // mode
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [OUT_TDATA_BITS-1:0] rsp_tdata;         // best_label, best_distance_sq
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = CSR_CENTROID_COUNT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // words waiting for the driver, and classifications waiting for the monitor
   sample_word_type  stim_words[$];
   class_result_type pending_results[$];

   // classifier model: store, running distance sums, register copies
   logic [VALUE_BITS-1:0] centroid_mem [STORE_DEPTH];
   logic [ACC_BITS-1:0]   dist_acc [MAX_CENTROIDS];
   logic [CC_BITS-1:0]    cfg_centroids = 5'd1;
   logic [CSC_BITS-1:0]   cfg_samples = 10'd512;

   // generator view of the store: which entries have been queued, and with what values
   bit                    loaded [STORE_DEPTH];
   logic [VALUE_BITS-1:0] planned_mem [STORE_DEPTH];
   clip_style_type        clip_style = STYLE_RANDOM;
   int unsigned           clip_target = 0;
   int unsigned           fed_words = 0;

   int                    error_count = 0;
   int unsigned           quiet_cycles = 0;

   // driver and receiver pacing
   sample_word_type       drive_word;
   int unsigned           burst_left = 1;
   int unsigned           gap_left = 0;
   int unsigned           stall_left = 0;
   int unsigned           ready_left = 0;

   nearest_centroid_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // zero reads as one, anything past the top reads as the top
   function automatic int unsigned clamp_setting(input int unsigned raw,
                                                 input int unsigned top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   function automatic int unsigned live_centroids();
      return clamp_setting(cfg_centroids, MAX_CENTROIDS);
   endfunction

   function automatic int unsigned live_samples();
      return clamp_setting(cfg_samples, MAX_CLIP_SAMPLES);
   endfunction

   // ---------------------------------------------------------------------------
   // Model of the classifier, run on every accepted input word
   // ---------------------------------------------------------------------------
   task automatic predict_word(input sample_word_type w);
      int unsigned                   nc;
      int unsigned                   ns;
      int unsigned                   k;
      int unsigned                   best;
      logic signed [VALUE_BITS:0]    diff;
      logic [VALUE_BITS:0]           mag;
      logic [2*VALUE_BITS+1:0]       sq;
      logic [ACC_BITS:0]             sum;
      logic [ACC_BITS-1:0]           acc_top;
      class_result_type              r;
      nc = live_centroids();
      ns = live_samples();
      acc_top = '1;
      if (w.mode == MODE_LOAD) begin
         centroid_mem[w.slot * MAX_CLIP_SAMPLES + w.pos] = w.value;
      end else if (w.pos < ns) begin
         // accumulate against every active centroid, saturating
         for (k = 0; k < nc; k++) begin
            diff = $signed(w.value) - $signed(centroid_mem[k * MAX_CLIP_SAMPLES + w.pos]);
            mag  = (diff < 0) ? -diff : diff;
            sq   = mag * mag;
            sum  = dist_acc[k] + sq;
            dist_acc[k] = (sum > acc_top) ? acc_top : sum[ACC_BITS-1:0];
         end
         // last sample closes the clip: strict less-than keeps the lowest index on ties
         if (w.pos == ns - 1) begin
            best = 0;
            for (k = 1; k < nc; k++) begin
               if (dist_acc[k] < dist_acc[best]) best = k;
            end
            r.label    = LABEL_BITS'(best + 1);
            r.distance = dist_acc[best];
            pending_results.push_back(r);
            for (k = 0; k < MAX_CENTROIDS; k++) dist_acc[k] = '0;
         end
      end
   endtask

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_result(input logic [OUT_TDATA_BITS-1:0] word);
      class_result_type      want;
      logic [LABEL_BITS-1:0] got_label;
      logic [ACC_BITS-1:0]   got_dist;
      got_label = word[LABEL_BITS-1:0];
      got_dist  = word[LABEL_BITS +: ACC_BITS];
      if (pending_results.size() == 0) begin
         note_error($sformatf("unexpected word, label %0d distance %0d", got_label, got_dist));
      end else begin
         want = pending_results.pop_front();
         if (got_label !== want.label)
            note_error($sformatf("label expected %0d got %0d", want.label, got_label));
         if (got_dist !== want.distance)
            note_error($sformatf("distance expected %0d got %0d", want.distance, got_dist));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic queue_load(input int unsigned slot, input int unsigned pos,
                             input logic [VALUE_BITS-1:0] value);
      sample_word_type w;
      w.mode  = MODE_LOAD;
      w.slot  = SLOT_BITS'(slot);
      w.pos   = POS_BITS'(pos);
      w.value = value;
      stim_words.push_back(w);
      planned_mem[slot * MAX_CLIP_SAMPLES + pos] = value;
      loaded[slot * MAX_CLIP_SAMPLES + pos] = 1'b1;
      fed_words++;
   endtask

   // slot field is a don't-care on clip words, so it gets noise
   task automatic queue_clip(input int unsigned pos, input logic [VALUE_BITS-1:0] value);
      sample_word_type w;
      w.mode  = MODE_CLIP;
      w.slot  = SLOT_BITS'($urandom_range(0, MAX_CENTROIDS - 1));
      w.pos   = POS_BITS'(pos);
      w.value = value;
      stim_words.push_back(w);
      if (pos < live_samples()) fed_words++;
   endtask

   function automatic logic [VALUE_BITS-1:0] extreme_value();
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] centroid_value();
      int v;
      case ($urandom_range(0, 5))
         0:       return extreme_value();
         1, 2: begin
            v = int'($urandom_range(0, 4)) - 2;
            return v[VALUE_BITS-1:0];
         end
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // a clip word must never read a store entry that was never written
   task automatic cover_position(input int unsigned pos);
      int unsigned k;
      if (pos < live_samples()) begin
         for (k = 0; k < live_centroids(); k++) begin
            if (!loaded[k * MAX_CLIP_SAMPLES + pos]) queue_load(k, pos, centroid_value());
         end
      end
   endtask

   function automatic logic [VALUE_BITS-1:0] clip_value(input int unsigned pos);
      int v;
      case (clip_style)
         STYLE_NEAR: begin
            v = $signed(planned_mem[clip_target * MAX_CLIP_SAMPLES + pos])
                + int'($urandom_range(0, 64)) - 32;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            if (v < SAMPLE_MIN) v = SAMPLE_MIN;
            return v[VALUE_BITS-1:0];
         end
         STYLE_RANDOM:  return VALUE_BITS'($urandom);
         STYLE_EXTREME: return extreme_value();
         default: begin
            v = int'($urandom_range(0, 4)) - 2;
            return v[VALUE_BITS-1:0];
         end
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_centroid_count();
      logic [CSR_DATA_BITS-1:0] d;
      d = CSR_DATA_BITS'($urandom);  // bits above the register are noise
      case ($urandom_range(0, 7))
         0:       d[CC_BITS-1:0] = '0;
         1:       d[CC_BITS-1:0] = CC_BITS'(1);
         2:       d[CC_BITS-1:0] = CC_BITS'(MAX_CENTROIDS);
         3:       d[CC_BITS-1:0] = CC_BITS'($urandom_range(MAX_CENTROIDS + 1, 31));
         default: d[CC_BITS-1:0] = CC_BITS'($urandom_range(2, MAX_CENTROIDS - 1));
      endcase
      return d;
   endfunction

   // mostly short clips, with zero, full length, too large and near-full counts mixed in
   function automatic logic [CSR_DATA_BITS-1:0] pick_sample_count();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return CSR_DATA_BITS'(MAX_CLIP_SAMPLES);
         2:       return CSR_DATA_BITS'($urandom_range(MAX_CLIP_SAMPLES + 1, 1023));
         3:       return CSR_DATA_BITS'($urandom_range(MAX_CLIP_SAMPLES - 32,
                                                       MAX_CLIP_SAMPLES - 1));
         4, 5:    return CSR_DATA_BITS'($urandom_range(9, 24));
         default: return CSR_DATA_BITS'($urandom_range(1, 8));
      endcase
   endfunction

   // registers only change with the block idle
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_CENTROID_COUNT) cfg_centroids = data[CC_BITS-1:0];
      else cfg_samples = data[CSC_BITS-1:0];
   endtask

   // all words sent, all classifications back, then let a silent clip word finish
   task automatic wait_idle();
      while (stim_words.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned i;
      int unsigned p;
      int unsigned ns;
      int unsigned first;
      int unsigned top;
      for (i = 0; i < STORE_DEPTH; i++) begin
         centroid_mem[i] = '0;
         planned_mem[i]  = '0;
         loaded[i]       = 1'b0;
      end
      for (i = 0; i < MAX_CENTROIDS; i++) dist_acc[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: one centroid, 512-sample clips, so position 511 closes a clip
      queue_load(0, MAX_CLIP_SAMPLES - 1, 16'h8000);
      queue_clip(MAX_CLIP_SAMPLES - 1, 16'h7FFF);   // widest possible difference
      queue_clip(MAX_CLIP_SAMPLES - 1, 16'h8000);   // exact match
      wait_idle();

      // bits above the count field are dropped: reads as two centroids
      write_reg(CSR_CENTROID_COUNT, {5'b10101, 5'd2});
      write_reg(CSR_CLIP_SAMPLE_COUNT, 10'd1);
      queue_load(0, 0, 16'd5);
      queue_load(1, 0, 16'd5);
      queue_clip(0, 16'd7);      // equal distances, lower label wins
      queue_load(1, 0, 16'd7);
      queue_clip(0, 16'd7);      // second centroid now exact
      queue_clip(1, 16'd100);    // past the clip end, ignored
      wait_idle();

      // zero in either register reads as one
      write_reg(CSR_CENTROID_COUNT, 10'd0);
      write_reg(CSR_CLIP_SAMPLE_COUNT, 10'd0);
      queue_clip(0, 16'h7FFF);
      wait_idle();

      // centroid count drops mid-clip; sums carry over
      write_reg(CSR_CENTROID_COUNT, 10'd3);
      write_reg(CSR_CLIP_SAMPLE_COUNT, 10'd3);
      clip_style  = STYLE_NEAR;
      clip_target = 2;
      for (p = 0; p < 2; p++) begin
         cover_position(p);
         queue_clip(p, clip_value(p));
      end
      wait_idle();
      write_reg(CSR_CENTROID_COUNT, 10'd1);
      clip_target = 0;
      cover_position(2);
      queue_clip(2, clip_value(2));
      wait_idle();

      // random phases: new settings, a few clips, then drain
      while (fed_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_CENTROID_COUNT, pick_centroid_count());
            1:       write_reg(CSR_CLIP_SAMPLE_COUNT, pick_sample_count());
            default: begin
               write_reg(CSR_CENTROID_COUNT, pick_centroid_count());
               write_reg(CSR_CLIP_SAMPLE_COUNT, pick_sample_count());
            end
         endcase
         ns = live_samples();
         repeat ($urandom_range(1, 5)) begin
            clip_style  = clip_style_type'($urandom_range(0, 3));
            clip_target = $urandom_range(0, live_centroids() - 1);
            case ($urandom_range(0, 9))
               7, 8: begin
                  // scrambled positions, repeats, early close, strays past the end
                  top = (ns + 2 < MAX_CLIP_SAMPLES) ? ns + 2 : MAX_CLIP_SAMPLES - 1;
                  repeat ($urandom_range(1, 10)) begin
                     p = $urandom_range(0, top);
                     cover_position(p);
                     queue_clip(p, clip_value(p));
                  end
               end
               9: begin
                  // stray reloads anywhere in the store, clip words past the end
                  repeat ($urandom_range(1, 6)) begin
                     if ($urandom_range(0, 1) == 0)
                        queue_load($urandom_range(0, MAX_CENTROIDS - 1),
                                   $urandom_range(0, MAX_CLIP_SAMPLES - 1),
                                   VALUE_BITS'($urandom));
                     else if (ns < MAX_CLIP_SAMPLES)
                        queue_clip($urandom_range(ns, MAX_CLIP_SAMPLES - 1),
                                   VALUE_BITS'($urandom));
                  end
               end
               default: begin
                  // in-order clip; long clips only get their tail
                  first = (ns > 24) ? ns - $urandom_range(1, 12) : 0;
                  for (p = first; p < ns; p++) begin
                     cover_position(p);
                     queue_clip(p, clip_value(p));
                  end
               end
            endcase
         end
         // sometimes leave a clip open across the next register change
         if (ns > 1 && $urandom_range(0, 3) == 0) begin
            top = $urandom_range(0, ns - 2);
            for (p = 0; p <= top; p++) begin
               cover_position(p);
               queue_clip(p, clip_value(p));
            end
         end
         wait_idle();
      end

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Driver: bursts of words with random gaps between them
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (stim_words.size() > 0) begin
            drive_word = stim_words.pop_front();
            req_tuser  <= drive_word.mode;
            req_tdata  <= {{(IN_TDATA_BITS - VALUE_BITS - POS_BITS - SLOT_BITS){1'b0}},
                           drive_word.value, drive_word.pos, drive_word.slot};
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 7))
                  0, 1, 2: gap_left = 0;
                  3, 4, 5: gap_left = $urandom_range(1, 3);
                  6:       gap_left = $urandom_range(4, 10);
                  default: gap_left = $urandom_range(11, 25);
               endcase
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: alternating stall and ready runs of random length
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0 && ready_left == 0) begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            ready_left = $urandom_range(1, 16);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            ready_left--;
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: model on accepted input, compare on accepted output, watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            predict_word({req_tuser, req_tdata[SLOT_BITS-1:0],
                          req_tdata[SLOT_BITS +: POS_BITS],
                          req_tdata[SLOT_BITS + POS_BITS +: VALUE_BITS]});
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

/* nearest_centroid_classifier.f */
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_ram.sv
hw/rtl/ncc_dist_unit.sv
hw/rtl/nearest_centroid_classifier.sv
tb/tb_nearest_centroid_classifier.sv
